FILE: rtl/core/clamped_time_difference_histogram_macros.svh
// Assertion macros shared by the histogram RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CLAMPED_TIME_DIFFERENCE_HISTOGRAM_MACROS_SVH
`define CLAMPED_TIME_DIFFERENCE_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTDH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ctdh_pkg.sv
// Package for the clamped time difference histogram: widths, defaults, codes.
// No dependencies.
`default_nettype none

package ctdh_pkg;

    localparam int DEF_POSITIONS = 17;
    localparam int DEF_CRYSTALS  = 4;
    localparam int DEF_BINS      = 32768;
    localparam int QUEUE_DEPTH   = 4;

    localparam int OP_W       = 1;
    localparam int POSITION_W = 5;
    localparam int CRYSTAL_W  = 2;
    localparam int PATTERN_W  = 16;
    localparam int CFD_W      = 32;
    localparam int STAMP_W    = 48;
    localparam int READ_BIN_W = 15;
    localparam int COUNT_W    = 32;
    localparam int OFFSET_W   = 15;

    localparam int TIME_BITS = 24;   // low bits of cfd and scaled stamp that are kept
    localparam int TS_SHIFT  = 4;    // stamp scaled by 16
    localparam int EDGE_BIN  = 10;   // clamp distance from either end

    localparam logic [OFFSET_W-1:0] TIME_OFFSET_RESET = 15'd16384;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // Work handed from the front to the back through the queue
    typedef enum logic [1:0] {
        KIND_INC  = 2'b00,   // increment one counter
        KIND_READ = 2'b01,   // return one counter
        KIND_ZERO = 2'b10    // read outside the store, return zero
    } t_kind;

endpackage

`default_nettype wire

FILE: rtl/core/ctdh_if.sv
// Valid/ready channel interfaces: hit input, count output, offset write.
// Depends on ctdh_pkg.
`default_nettype none

interface ctdh_hit_if;
    logic                                valid;
    logic                                ready;
    logic [ctdh_pkg::OP_W-1:0]           operation;
    logic [ctdh_pkg::POSITION_W-1:0]     position;
    logic [ctdh_pkg::CRYSTAL_W-1:0]      crystal;
    logic [ctdh_pkg::PATTERN_W-1:0]      hit_pattern;
    logic [ctdh_pkg::CFD_W-1:0]          cfd_time;
    logic [ctdh_pkg::STAMP_W-1:0]        time_stamp;
    logic [ctdh_pkg::READ_BIN_W-1:0]     read_bin;

    modport source (output valid, operation, position, crystal, hit_pattern, cfd_time,
                    time_stamp, read_bin, input ready);
    modport sink   (input valid, operation, position, crystal, hit_pattern, cfd_time,
                    time_stamp, read_bin, output ready);
endinterface

interface ctdh_count_if;
    logic                            valid;
    logic                            ready;
    logic [ctdh_pkg::COUNT_W-1:0]    bin_count;

    modport source (output valid, bin_count, input ready);
    modport sink   (input valid, bin_count, output ready);
endinterface

interface ctdh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ctdh_pkg::OFFSET_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ctdh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ctdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/ctdh_fifo.sv
// Short flop-based queue between the classifying front and the memory back.
// Depends on the assertion macro header.
`default_nettype none
`include "clamped_time_difference_histogram_macros.svh"

module ctdh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_ready,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_data,
    output      logic             o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    `CTDH_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `CTDH_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "push lost")
    `CTDH_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1, "pop lost")

endmodule

`default_nettype wire

FILE: rtl/core/ctdh_front.sv
// Front part: takes hit/read transactions, computes bank and clamped bin,
// drops hits that are never counted. Depends on ctdh_pkg and ctdh_if.
`default_nettype none

module ctdh_front #(
    parameter int POSITIONS = ctdh_pkg::DEF_POSITIONS,
    parameter int CRYSTALS  = ctdh_pkg::DEF_CRYSTALS,
    parameter int BINS      = ctdh_pkg::DEF_BINS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ctdh_hit_if.sink                             i_hit,
    input  wire logic                            i_clearing,
    input  wire logic [ctdh_pkg::OFFSET_W-1:0]   i_time_offset,
    output      logic                            o_push,
    input  wire logic                            i_push_ready,
    output      logic [$bits(ctdh_pkg::t_kind) + $clog2(POSITIONS * CRYSTALS)
                       + $clog2(BINS) - 1:0]     o_entry
);

    localparam int BANKS   = POSITIONS * CRYSTALS;
    localparam int BANK_W  = $clog2(BANKS);
    localparam int BIN_W   = $clog2(BINS);
    localparam int KIND_W  = $bits(ctdh_pkg::t_kind);
    localparam int ENTRY_W = KIND_W + BANK_W + BIN_W;
    localparam int TW      = ctdh_pkg::TIME_BITS + 2;   // signed difference plus offset
    localparam int SCALED_W = ctdh_pkg::TIME_BITS - ctdh_pkg::TS_SHIFT;

    logic                r_valid;
    logic [ENTRY_W-1:0]  r_entry;

    logic                w_take, w_keep, w_bank_ok, w_read_ok;
    logic [TW-1:0]       w_diff;
    logic                w_neg, w_high;
    logic [BIN_W-1:0]    w_bin, w_hit_bin;
    logic [BANK_W-1:0]   w_bank;
    ctdh_pkg::t_kind     w_kind;

    assign i_hit.ready = !i_clearing && (!r_valid || i_push_ready);
    assign w_take      = i_hit.valid && i_hit.ready;

    assign w_bank_ok = (7'(i_hit.position) < 7'(POSITIONS))
                    && (5'(i_hit.crystal) < 5'(CRYSTALS));
    assign w_read_ok = w_bank_ok && (17'(i_hit.read_bin) < 17'(BINS));
    assign w_bank    = BANK_W'(BANK_W'(i_hit.position) * BANK_W'(CRYSTALS)
                     + BANK_W'(i_hit.crystal));

    // cfd minus scaled stamp, both cut to 24 bits, plus the offset
    assign w_diff = TW'(i_hit.cfd_time[ctdh_pkg::TIME_BITS-1:0])
                  - TW'({i_hit.time_stamp[SCALED_W-1:0], {ctdh_pkg::TS_SHIFT{1'b0}}})
                  + TW'(i_time_offset);
    assign w_neg  = w_diff[TW-1];
    assign w_high = (w_diff >= TW'(BINS));

    always_comb begin
        priority if (w_neg) begin
            w_hit_bin = BIN_W'(ctdh_pkg::EDGE_BIN);
        end else if (w_high) begin
            w_hit_bin = BIN_W'(BINS - ctdh_pkg::EDGE_BIN);
        end else begin
            w_hit_bin = w_diff[BIN_W-1:0];
        end
    end

    always_comb begin
        unique case (ctdh_pkg::t_op'(i_hit.operation))
            ctdh_pkg::OP_READ: begin
                w_keep = 1'b1;
                w_kind = w_read_ok ? ctdh_pkg::KIND_READ : ctdh_pkg::KIND_ZERO;
                w_bin  = BIN_W'(i_hit.read_bin);
            end
            default: begin
                w_keep = i_hit.hit_pattern[0] && (i_hit.position != '0) && w_bank_ok;
                w_kind = ctdh_pkg::KIND_INC;
                w_bin  = w_hit_bin;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_push_ready) begin
            r_valid <= w_take && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry <= {w_kind, w_bank, w_bin};
        end
    end

    assign o_push  = r_valid;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: rtl/core/ctdh_back.sv
// Back part: clears the counter store after reset, then runs each queued
// increment or read against it. Depends on ctdh_pkg, ctdh_if, ctdh_ram, macros.
`default_nettype none
`include "clamped_time_difference_histogram_macros.svh"

module ctdh_back #(
    parameter int POSITIONS = ctdh_pkg::DEF_POSITIONS,
    parameter int CRYSTALS  = ctdh_pkg::DEF_CRYSTALS,
    parameter int BINS      = ctdh_pkg::DEF_BINS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire logic [$bits(ctdh_pkg::t_kind) + $clog2(POSITIONS * CRYSTALS)
                       + $clog2(BINS) - 1:0]     i_q_entry,
    output      logic                            o_pop,
    output      logic                            o_clearing,
    ctdh_count_if.source                         o_count
);

    localparam int BANKS   = POSITIONS * CRYSTALS;
    localparam int BANK_W  = $clog2(BANKS);
    localparam int BIN_W   = $clog2(BINS);
    localparam int KIND_W  = $bits(ctdh_pkg::t_kind);
    localparam int ENTRY_W = KIND_W + BANK_W + BIN_W;
    localparam int DEPTH   = BANKS * BINS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CW      = ctdh_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_MODIFY = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    ctdh_pkg::t_kind   r_kind;
    logic              r_out_valid, n_out_valid;
    logic [CW-1:0]     r_out_data, n_out_data;

    ctdh_pkg::t_kind   w_kind;
    logic [BANK_W-1:0] w_bank;
    logic [BIN_W-1:0]  w_bin;
    logic [ADDR_W-1:0] w_addr;
    logic              w_slot_free, w_issue;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CW-1:0]     w_wdata, w_rdata;

    assign w_kind = ctdh_pkg::t_kind'(i_q_entry[ENTRY_W-1 -: KIND_W]);
    assign w_bank = i_q_entry[BANK_W+BIN_W-1 -: BANK_W];
    assign w_bin  = i_q_entry[BIN_W-1:0];
    assign w_addr = ADDR_W'(w_bank) * ADDR_W'(BINS) + ADDR_W'(w_bin);

    // Output slot empty now or emptied by the sink this cycle
    assign w_slot_free = !r_out_valid || o_count.ready;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !o_count.ready;
        n_out_data  = r_out_data;
        w_issue     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = (w_rdata == '1) ? w_rdata : w_rdata + 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (w_kind)
                        ctdh_pkg::KIND_INC: begin
                            w_issue = 1'b1;
                            n_state = S_MODIFY;
                        end
                        ctdh_pkg::KIND_READ: begin
                            if (w_slot_free) begin
                                w_issue = 1'b1;
                                n_state = S_MODIFY;
                            end
                        end
                        default: begin
                            if (w_slot_free) begin
                                w_issue     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '0;
                            end
                        end
                    endcase
                end
            end
            S_MODIFY: begin
                n_state = S_IDLE;
                if (r_kind == ctdh_pkg::KIND_INC) begin
                    w_we = 1'b1;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_rdata;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_issue) begin
            r_addr <= w_addr;
            r_kind <= w_kind;
        end
    end

    ctdh_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign o_pop             = w_issue;
    assign o_clearing        = (r_state == S_CLEAR);
    assign o_count.valid     = r_out_valid;
    assign o_count.bin_count = r_out_data;

    `CTDH_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_pop, "queue popped during clear")
    `CTDH_ASSERT_NOW(a_read_slot_free, i_clk, i_rst_n, (r_state == S_MODIFY) && (r_kind != ctdh_pkg::KIND_INC), !r_out_valid, "read result would overwrite pending count")
    `CTDH_ASSERT_NOW(a_write_source, i_clk, i_rst_n, w_we, (r_state == S_CLEAR) || ((r_state == S_MODIFY) && (r_kind == ctdh_pkg::KIND_INC)), "store written outside clear or increment")
    `CTDH_ASSERT_NEXT(a_issue_then_idle, i_clk, i_rst_n, r_state == S_MODIFY, r_state == S_IDLE, "modify cycle did not return to idle")

endmodule

`default_nettype wire

FILE: rtl/core/clamped_time_difference_histogram.sv
// Top level of the clamped time difference histogram.
// Depends on ctdh_pkg, ctdh_if, ctdh_front, ctdh_fifo, ctdh_back.
`default_nettype none

// A bank of BINS saturating 32-bit counters per (position, crystal) pair, held in
// one RAM of POSITIONS*CRYSTALS*BINS words. A record transaction (operation 0)
// with hit_pattern bit 0 set, a non-zero in-range position and an in-range crystal
// bumps one counter; its bin is cfd[23:0] - (stamp*16)[23:0] + time_offset, forced
// to 10 when negative and to BINS-10 when at or above BINS. Other records vanish.
// A read transaction (operation 1) returns one count on the output channel, or 0
// when position, crystal or read_bin lies outside the store. After reset the store
// is zeroed one word per cycle, during which the hit channel is not ready; offset
// writes are taken at any time and are always ready. The front registers each
// accepted transaction, a four-entry queue follows, and the back does a counted
// hit or in-range read as a RAM read followed by a write or output load, and
// answers an out-of-range read without the RAM; a new queued entry waits until
// the read-modify-write on the single RAM is done. The count stays in an output
// register until taken, while the front keeps accepting until the queue fills.

module clamped_time_difference_histogram #(
    parameter int POSITIONS = ctdh_pkg::DEF_POSITIONS,
    parameter int CRYSTALS  = ctdh_pkg::DEF_CRYSTALS,
    parameter int BINS      = ctdh_pkg::DEF_BINS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    ctdh_hit_if.sink       i_hit,
    ctdh_cfg_if.sink       i_cfg,
    ctdh_count_if.source   o_count
);

    localparam int ENTRY_W = $bits(ctdh_pkg::t_kind) + $clog2(POSITIONS * CRYSTALS)
                           + $clog2(BINS);

    // Offset register; a write lands whenever the channel is valid
    logic [ctdh_pkg::OFFSET_W-1:0] r_time_offset;

    // Front to queue
    logic               w_push, w_push_ready;
    logic [ENTRY_W-1:0] w_push_entry;

    // Queue to back
    logic               w_q_valid, w_pop;
    logic [ENTRY_W-1:0] w_q_entry;

    logic               w_clearing;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_offset <= ctdh_pkg::TIME_OFFSET_RESET;
        end else if (i_cfg.valid) begin
            r_time_offset <= i_cfg.data;
        end
    end

    ctdh_front #(
        .POSITIONS (POSITIONS),
        .CRYSTALS  (CRYSTALS),
        .BINS      (BINS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hit         (i_hit),
        .i_clearing    (w_clearing),
        .i_time_offset (r_time_offset),
        .o_push        (w_push),
        .i_push_ready  (w_push_ready),
        .o_entry       (w_push_entry)
    );

    ctdh_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (ctdh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_ready (w_push_ready),
        .i_pop   (w_pop),
        .o_data  (w_q_entry),
        .o_valid (w_q_valid)
    );

    ctdh_back #(
        .POSITIONS (POSITIONS),
        .CRYSTALS  (CRYSTALS),
        .BINS      (BINS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_q_entry),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_count    (o_count)
    );

endmodule

`default_nettype wire
